/* rtl/vds_pkg.sv */
// Shared types, widths and codes for the vector distance scanner.
// Used by every module of the block apart from the generic RAM.
package vds_pkg;

  // Field widths of the stream words.
  localparam int unsigned ELEM_W = 16;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned DIM_W  = 11;
  localparam int unsigned ROW_W  = 32;
  localparam int unsigned DIST_W = 48;

  // One squared 17-bit difference is the widest term.
  localparam int unsigned TERM_W = 2 * ELEM_W + 2;

  // Default query store depth.
  localparam int unsigned MAX_DIM_DEF = 1024;

  // Result queue depth; it also bounds the number of words in flight.
  localparam int unsigned OFIFO_DEPTH = 4;

  // Configuration port.
  localparam int unsigned CFG_AW = 1;
  localparam int unsigned CFG_DW = DIM_W;
  localparam logic [CFG_AW-1:0] REG_METRIC    = 1'b0;
  localparam logic [CFG_AW-1:0] REG_DIMENSION = 1'b1;

  // Metric codes.
  localparam logic METRIC_L2 = 1'b0;
  localparam logic METRIC_IP = 1'b1;

  // Input word kinds.
  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_BASE  = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd128;

  // Saturation bounds of the distance field.
  localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  // Control and data of one word moving down the pipeline.
  typedef struct packed {
    logic              valid;
    logic              clr;     // query load: clears the accumulator
    logic              last;    // closes a row
    logic              metric;
    logic [ROW_W-1:0]  row;
    logic [ELEM_W-1:0] value;
  } stage_t;

  // One finished row.
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] distance;
    logic [ROW_W-1:0]  row;
  } result_t;

endpackage

/* rtl/vds_ram.sv */
// Generic single-clock RAM: one write port and one read port with a
// registered read. No dependencies.
module vds_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/vds_ctrl.sv */
// Front end of the scanner: element position and row counters, query store
// addressing, and the first pipeline register. Depends on vds_pkg.
module vds_ctrl #(
  parameter int unsigned MAX_DIM = vds_pkg::MAX_DIM_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       cmd_i,
  input  logic [vds_pkg::IDX_W-1:0]  idx_i,
  input  logic [vds_pkg::ELEM_W-1:0] value_i,
  input  logic                       metric_i,
  input  logic [vds_pkg::DIM_W-1:0]  dimension_i,
  output logic                       ram_we_o,
  output logic [$clog2(MAX_DIM)-1:0] ram_waddr_o,
  output logic [vds_pkg::ELEM_W-1:0] ram_wdata_o,
  output logic                       ram_re_o,
  output logic [$clog2(MAX_DIM)-1:0] ram_raddr_o,
  output vds_pkg::stage_t            stage_o
);
  import vds_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_DIM);
  localparam int unsigned POS_W = $clog2(MAX_DIM + 1);

  logic [POS_W-1:0] pos_q, pos_d, pos_next, eff_dim;
  logic [ROW_W-1:0] row_q, row_d;
  stage_t           stage_q, stage_d;
  logic             last;
  logic             idx_ok;

  // Dimension in force: zero acts as one, and it never exceeds the store.
  always_comb begin
    if (dimension_i == '0) begin
      eff_dim = POS_W'(1);
    end else if (32'(dimension_i) > MAX_DIM) begin
      eff_dim = POS_W'(MAX_DIM);
    end else begin
      eff_dim = POS_W'(dimension_i);
    end
  end

  assign pos_next = pos_q + POS_W'(1);
  assign last     = (pos_next >= eff_dim);
  assign idx_ok   = (32'(idx_i) < MAX_DIM);

  // Counter update and the word handed to the arithmetic stages.
  always_comb begin
    pos_d          = pos_q;
    row_d          = row_q;
    stage_d.valid  = accept_i;
    stage_d.clr    = (cmd_i == CMD_QUERY);
    stage_d.last   = last;
    stage_d.metric = metric_i;
    stage_d.row    = row_q;
    stage_d.value  = value_i;
    if (accept_i) begin
      if (cmd_i == CMD_QUERY) begin
        pos_d = '0;
        row_d = '0;
      end else if (last) begin
        pos_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        pos_d = pos_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      row_q   <= '0;
      stage_q <= '0;
    end else begin
      pos_q   <= pos_d;
      row_q   <= row_d;
      stage_q <= stage_d;
    end
  end

  // Query loads write the store; base words read the entry at the position.
  assign ram_we_o    = accept_i && (cmd_i == CMD_QUERY) && idx_ok;
  assign ram_waddr_o = AW'(idx_i);
  assign ram_wdata_o = value_i;
  assign ram_re_o    = accept_i && (cmd_i == CMD_BASE);
  assign ram_raddr_o = pos_q[AW-1:0];
  assign stage_o     = stage_q;

  // A query load restarts the row and element counts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (cmd_i == CMD_QUERY)) |=> (pos_q == '0) && (row_q == '0))
    else $error("counters not cleared after query load");

  // The position always addresses a store entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < MAX_DIM)
    else $error("element position beyond query store");

  // A finished row advances the row count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (cmd_i == CMD_BASE) && last) |=>
      (row_q == $past(row_q) + ROW_W'(1)) && (pos_q == '0))
    else $error("row count did not advance at row end");

endmodule

/* rtl/vds_mac.sv */
// Arithmetic stages: squared difference or product against the query
// element, then exact accumulation and saturation. Depends on vds_pkg.
module vds_mac #(
  parameter int unsigned MAX_DIM = vds_pkg::MAX_DIM_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vds_pkg::stage_t            stage_i,
  input  logic [vds_pkg::ELEM_W-1:0] qdata_i,
  output vds_pkg::result_t           result_o,
  output logic                       busy_o
);
  import vds_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_DIM + 1);
  localparam int unsigned ACC_W = TERM_W + POS_W;

  logic signed [ELEM_W:0]     diff;
  logic signed [TERM_W-1:0]   sq;
  logic signed [2*ELEM_W-1:0] prod;
  logic signed [TERM_W-1:0]   term_d, term_q;
  stage_t                     s2_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d, acc_sum;
  logic [DIST_W-1:0]          dist_fit;

  // Term of one element, from the query entry read in the previous cycle.
  assign diff = $signed({qdata_i[ELEM_W-1], qdata_i})
              - $signed({stage_i.value[ELEM_W-1], stage_i.value});
  assign sq   = diff * diff;
  assign prod = $signed(qdata_i) * $signed(stage_i.value);

  always_comb begin
    if (stage_i.metric == METRIC_IP) begin
      term_d = TERM_W'(prod);
    end else begin
      term_d = sq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else begin
      s2_q <= stage_i;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
  end

  // Accumulator: clears on a query load and after each finished row.
  assign acc_sum = acc_q + ACC_W'(term_q);

  always_comb begin
    acc_d = acc_q;
    if (s2_q.valid) begin
      if (s2_q.clr || s2_q.last) begin
        acc_d = '0;
      end else begin
        acc_d = acc_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // Fit the exact sum to the distance field.
  if (ACC_W > DIST_W) begin : g_sat
    logic [ACC_W-DIST_W:0] hi;
    assign hi = acc_sum[ACC_W-1:DIST_W-1];
    always_comb begin
      if ((&hi) || !(|hi)) begin
        dist_fit = acc_sum[DIST_W-1:0];
      end else if (acc_sum[ACC_W-1]) begin
        dist_fit = DIST_MIN;
      end else begin
        dist_fit = DIST_MAX;
      end
    end
  end else begin : g_ext
    assign dist_fit = DIST_W'(acc_sum);
  end

  assign result_o.valid    = s2_q.valid && !s2_q.clr && s2_q.last;
  assign result_o.distance = dist_fit;
  assign result_o.row      = s2_q.row;
  assign busy_o            = s2_q.valid;

  // Every word entering the arithmetic stage reaches the accumulator.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_i.valid |=> busy_o)
    else $error("word lost between arithmetic stages");

  // A query load leaves a cleared accumulator.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_q.valid && s2_q.clr) |=> (acc_q == '0))
    else $error("accumulator not cleared by query load");

  // A result is never taken from a query load word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> !s2_q.clr)
    else $error("result raised by query load");

endmodule

/* rtl/vector_distance_scan.sv */
// Vector distance scanner: a query store, a multiply-accumulate pipeline and a
// four-deep result queue. Depends on vds_pkg, vds_ram, vds_ctrl and vds_mac.
//
// The block takes one input word per clock cycle while the input is not stalled,
// query loads and base elements alike. Each base element reads the query store
// (one synchronous RAM with a registered read) as it enters the first pipeline
// register, forms its term in the next cycle and is accumulated in the cycle
// after, so a row's result is written into the output queue straight from the
// accumulator stage, and the queue offers it on the result stream. The
// four-entry result queue covers every word in flight; the input stalls only
// when the queue and the pipeline together hold four words, which happens only
// after the output side has held off taking results. The query store needs no
// clearing pass after reset, and a query element must be written before it is used.
module vector_distance_scan #(
  parameter int unsigned MAX_DIM = vds_pkg::MAX_DIM_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input stream.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,  // [9:0] elem_index, [25:10] value
  input  logic [0:0]                 s_axis_tuser,  // [0] cmd
  // Result stream.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [79:0]                m_axis_tdata,  // [47:0] distance, [79:48] row_index
  // Configuration writes.
  input  logic                       cfg_we_i,
  input  logic [vds_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [vds_pkg::CFG_DW-1:0] cfg_wdata_i
);
  import vds_pkg::*;

  localparam int unsigned AW     = $clog2(MAX_DIM);
  localparam int unsigned FIFO_AW = $clog2(OFIFO_DEPTH);
  localparam int unsigned CNT_W  = $clog2(OFIFO_DEPTH + 1);

  logic                  metric_q;
  logic [DIM_W-1:0]      dim_q;
  logic                  accept;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [ELEM_W-1:0]     ram_wdata, ram_rdata;
  stage_t                stage1;
  result_t               result;
  logic                  mac_busy;
  logic [DIST_W+ROW_W-1:0] fifo_q [OFIFO_DEPTH];
  logic [FIFO_AW-1:0]    wptr_q, rptr_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [CNT_W:0]        credit;
  logic                  push, pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= METRIC_L2;
      dim_q    <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_METRIC:    metric_q <= cfg_wdata_i[0];
        REG_DIMENSION: dim_q    <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Input is taken while the queue has room for every word in flight.
  assign credit = (CNT_W+1)'(cnt_q) + (CNT_W+1)'(stage1.valid) + (CNT_W+1)'(mac_busy);
  assign s_axis_tready = (credit < (CNT_W+1)'(OFIFO_DEPTH));
  assign accept = s_axis_tvalid && s_axis_tready;

  vds_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (s_axis_tuser[0]),
    .idx_i       (s_axis_tdata[IDX_W-1:0]),
    .value_i     (s_axis_tdata[IDX_W+ELEM_W-1:IDX_W]),
    .metric_i    (metric_q),
    .dimension_i (dim_q),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .stage_o     (stage1)
  );

  vds_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_DIM)) u_query_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  vds_mac #(.MAX_DIM(MAX_DIM)) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (stage1),
    .qdata_i  (ram_rdata),
    .result_o (result),
    .busy_o   (mac_busy)
  );

  // Result queue.
  assign push = result.valid;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= {result.row, result.distance};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + FIFO_AW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = fifo_q[rptr_q];

  // The queue never overfills.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(OFIFO_DEPTH))
    else $error("result queue count beyond depth");

  // A result never arrives at a full queue unless one leaves in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && (cnt_q == CNT_W'(OFIFO_DEPTH))) |-> pop)
    else $error("result pushed into full queue");

  // Words in flight plus queued results stay within the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit <= (CNT_W+1)'(OFIFO_DEPTH))
    else $error("more words in flight than queue entries");

endmodule

/* tb/sv/tb_vector_distance_scan.sv */
// Self-checking testbench for the vector distance scanner: directed tests, then random scans.
// It predicts every result word in its own scan model and checks each one as it leaves.
// Depends on vds_pkg and on the vector_distance_scan top level.
module tb_vector_distance_scan;
  import vds_pkg::*;

  localparam int unsigned QSTORE_DEPTH = MAX_DIM_DEF;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned HOLD_CYCLES  = 300;

  // One finished row as the block should report it.
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [ROW_W-1:0]  row;
  } scan_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata  = '0;  // [9:0] elem_index, [25:10] value
  logic [0:0]          s_axis_tuser  = '0;  // [0] cmd
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [79:0]         m_axis_tdata;        // [47:0] distance, [79:48] row_index
  logic                cfg_we_i      = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr_i    = '0;
  logic [CFG_DW-1:0]   cfg_wdata_i   = '0;

  // Scan model state and configuration.
  logic signed [ELEM_W-1:0] query_mem [QSTORE_DEPTH];
  longint                   acc_sum    = 0;
  int unsigned              elem_pos   = 0;
  logic [ROW_W-1:0]         rows_done  = '0;
  logic                     cur_metric = METRIC_L2;
  logic [DIM_W-1:0]         cur_dim    = DIM_RESET;

  scan_result_t expected_rows [$];
  int unsigned  error_count  = 0;
  int unsigned  words_sent   = 0;
  int unsigned  burst_left   = 0;
  int unsigned  hold_request = 0;

  vector_distance_scan #(
    .MAX_DIM(QSTORE_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the scan model by one accepted input word.
  function automatic void advance_scan(input logic cmd, input logic [IDX_W-1:0] idx,
                                       input logic signed [ELEM_W-1:0] val);
    int unsigned dim_eff;
    int unsigned rd_pos;
    longint      q;
    longint      diff;
    longint      term;
    longint      total;
    scan_result_t res;
    if (cmd == CMD_QUERY) begin
      query_mem[idx] = val;
      rows_done = '0;
      elem_pos  = 0;
      acc_sum   = 0;
      return;
    end
    if (cur_dim == 0) begin
      dim_eff = 1;
    end else if (cur_dim > QSTORE_DEPTH) begin
      dim_eff = QSTORE_DEPTH;
    end else begin
      dim_eff = cur_dim;
    end
    rd_pos = (elem_pos >= QSTORE_DEPTH) ? QSTORE_DEPTH - 1 : elem_pos;
    q = query_mem[rd_pos];
    if (cur_metric == METRIC_L2) begin
      diff = q - longint'(val);
      term = diff * diff;
    end else begin
      term = q * longint'(val);
    end
    acc_sum += term;
    elem_pos++;
    if (elem_pos < dim_eff) return;
    // The row is complete: saturate to the distance field and queue the result.
    total = acc_sum;
    if (total > longint'($signed(DIST_MAX))) total = longint'($signed(DIST_MAX));
    if (total < longint'($signed(DIST_MIN))) total = longint'($signed(DIST_MIN));
    res.distance = total[DIST_W-1:0];
    res.row      = rows_done;
    expected_rows.push_back(res);
    rows_done++;
    elem_pos = 0;
    acc_sum  = 0;
  endfunction

  // Element values lean on the extremes of Q1.15 now and then.
  function automatic logic signed [ELEM_W-1:0] elem_value();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Offer one input word and hold it until the block takes it.
  task automatic send_word(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic signed [ELEM_W-1:0] val);
    pace_sender();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, val, idx};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_scan(cmd, idx, val);
    words_sent++;
  endtask

  task automatic send_base(input logic signed [ELEM_W-1:0] val);
    send_word(CMD_BASE, IDX_W'($urandom), val);
  endtask

  // Stop sending, wait for every expected result, then let the pipeline settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (addr == REG_METRIC) begin
      cur_metric = data[0];
    end else begin
      cur_dim = data;
    end
  endtask

  task automatic configure(input logic metric_sel, input int unsigned dim);
    wait_idle();
    write_reg(REG_METRIC, CFG_DW'(metric_sel));
    write_reg(REG_DIMENSION, CFG_DW'(dim));
  endtask

  // Fill the whole query store, then scan one row with the reset settings.
  task automatic test_reset_defaults();
    for (int i = 0; i < QSTORE_DEPTH; i++) begin
      send_word(CMD_QUERY, IDX_W'(i), elem_value());
    end
    for (int i = 0; i < DIM_RESET; i++) begin
      send_base(elem_value());
    end
    wait_idle();
  endtask

  // Largest squares, largest and smallest products, zeros and the top query index.
  task automatic test_field_extremes();
    configure(METRIC_L2, 4);
    send_word(CMD_QUERY, 10'd1023, 16'sh7fff);
    send_word(CMD_QUERY, 10'd0, 16'sh8000);
    send_word(CMD_QUERY, 10'd1, 16'sh7fff);
    send_word(CMD_QUERY, 10'd2, 16'sh8000);
    send_word(CMD_QUERY, 10'd3, 16'sh7fff);
    for (int i = 0; i < 4; i++) send_base((i % 2 == 0) ? 16'sh7fff : 16'sh8000);
    for (int i = 0; i < 4; i++) send_base(16'sh0000);
    configure(METRIC_IP, 4);
    for (int i = 0; i < 4; i++) send_base((i % 2 == 0) ? 16'sh8000 : 16'sh7fff);
    for (int i = 0; i < 4; i++) send_base((i % 2 == 0) ? 16'sh7fff : 16'sh8000);
    wait_idle();
  endtask

  // A dimension of zero acts as one and one above the store depth acts as the depth.
  task automatic test_dimension_bounds();
    configure(METRIC_IP, 0);
    for (int i = 0; i < 3; i++) send_base(elem_value());
    configure(METRIC_L2, 1);
    for (int i = 0; i < 2; i++) send_base(elem_value());
    configure(METRIC_IP, (1 << DIM_W) - 1);
    for (int i = 0; i < QSTORE_DEPTH; i++) send_base(elem_value());
    configure(METRIC_L2, QSTORE_DEPTH);
    for (int i = 0; i < QSTORE_DEPTH; i++) send_base(elem_value());
    wait_idle();
  endtask

  // A query word in the middle of a row restarts the row and the row count.
  task automatic test_query_reload();
    configure(METRIC_L2, 8);
    for (int i = 0; i < 5; i++) send_base(elem_value());
    send_word(CMD_QUERY, 10'd3, elem_value());
    for (int i = 0; i < 16; i++) send_base(elem_value());
    wait_idle();
  endtask

  // The row ends at the first word where the position reaches the new dimension.
  task automatic test_dimension_change();
    configure(METRIC_IP, 10);
    for (int i = 0; i < 6; i++) send_base(elem_value());
    wait_idle();
    write_reg(REG_DIMENSION, CFG_DW'(4));
    for (int i = 0; i < 5; i++) send_base(elem_value());
    configure(METRIC_L2, 3);
    for (int i = 0; i < 2; i++) send_base(elem_value());
    wait_idle();
    write_reg(REG_DIMENSION, CFG_DW'(6));
    for (int i = 0; i < 4; i++) send_base(elem_value());
    wait_idle();
  endtask

  // Each word uses the metric in force when it arrives.
  task automatic test_metric_change();
    configure(METRIC_L2, 6);
    for (int i = 0; i < 3; i++) send_base(elem_value());
    wait_idle();
    write_reg(REG_METRIC, CFG_DW'(METRIC_IP));
    for (int i = 0; i < 6; i++) send_base(elem_value());
    wait_idle();
    write_reg(REG_METRIC, CFG_DW'(METRIC_L2));
    for (int i = 0; i < 3; i++) send_base(elem_value());
    wait_idle();
  endtask

  // The receiver holds off while every word makes a result, so the input must stall.
  task automatic test_backpressure();
    configure(METRIC_IP, 1);
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_base(elem_value());
    wait_idle();
  endtask

  // Random phases: new settings, a partial query load, whole rows, noise and cut-off rows.
  task automatic test_random_scan();
    int unsigned start;
    int unsigned dim;
    int unsigned rows;
    int unsigned loads;
    int unsigned pick;
    start = words_sent;
    while (words_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        dim = $urandom_range(1, 16);
      end else if (pick < 96) begin
        dim = $urandom_range(17, 64);
      end else begin
        dim = $urandom_range(65, 300);
      end
      configure(1'($urandom_range(0, 1)), dim);
      loads = $urandom_range(0, (dim < 8) ? dim : 8);
      for (int i = 0; i < loads; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_word(CMD_QUERY, IDX_W'($urandom_range(0, QSTORE_DEPTH - 1)), elem_value());
        end else begin
          send_word(CMD_QUERY, IDX_W'($urandom_range(0, dim - 1)), elem_value());
        end
      end
      rows = (dim > 64) ? 1 : $urandom_range(1, 4);
      for (int r = 0; r < rows; r++) begin
        for (int e = 0; e < dim; e++) begin
          if ($urandom_range(0, 99) < 2) begin
            send_word(CMD_QUERY, IDX_W'($urandom_range(0, QSTORE_DEPTH - 1)), elem_value());
          end
          send_base(elem_value());
        end
      end
      // Leave a row unfinished now and then; the next phase picks it up.
      if ($urandom_range(0, 9) < 3) begin
        for (int e = 0; e < $urandom_range(1, dim); e++) send_base(elem_value());
        if ($urandom_range(0, 1) == 0) begin
          send_word(CMD_QUERY, IDX_W'($urandom_range(0, dim - 1)), elem_value());
        end
      end
    end
    wait_idle();
  endtask

  // Result checker and receiver stall pattern.
  initial begin : result_sink
    scan_result_t      want;
    logic [DIST_W-1:0] got_dist;
    logic [ROW_W-1:0]  got_row;
    int unsigned       hold_left;
    int unsigned       run_left;
    int unsigned       ready_pct;
    hold_left = 0;
    run_left  = 0;
    ready_pct = 100;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got_dist = m_axis_tdata[DIST_W-1:0];
        got_row  = m_axis_tdata[79:48];
        if (expected_rows.size() == 0) begin
          error_count++;
          $display("%0t: result word with nothing expected: distance %0d row %0d",
                   $time, $signed(got_dist), got_row);
        end else begin
          want = expected_rows.pop_front();
          if (got_dist !== want.distance) begin
            error_count++;
            $display("%0t: distance expected %0d actual %0d",
                     $time, $signed(want.distance), $signed(got_dist));
          end
          if (got_row !== want.row) begin
            error_count++;
            $display("%0t: row_index expected %0d actual %0d", $time, want.row, got_row);
          end
        end
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      // Ready probability changes in runs, including runs with no stalls at all.
      if (run_left == 0) begin
        run_left = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 40;
          default: ready_pct = 10;
        endcase
      end
      run_left--;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  // Watchdog: too many cycles without any word moving on either side.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin : test_sequence
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_field_extremes();
    test_dimension_bounds();
    test_query_reload();
    test_dimension_change();
    test_metric_change();
    test_backpressure();
    test_random_scan();
    wait_idle();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
